### hw/rtl/arpenc_pkg.sv
// Shared types and constants of the ARP-in-IPv4 encapsulator.
`default_nettype none

package arpenc_pkg;

	// Input beat kinds.
	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_TABLE = 1'b1;

	// Configuration register indexes (paddr[3]).
	localparam logic REG_DST_MAC     = 1'b0;
	localparam logic REG_ENCAP_PROTO = 1'b1;

	// Frame geometry.
	localparam int MIN_FRAME  = 42;
	localparam int HDR_GROWTH = 20;
	localparam int IP_LEN_ADJ = 6;
	localparam int WORD_BYTES = 8;
	localparam int HDR_WORDS  = 4;
	localparam int HDR_BITS   = 272;

	// Byte positions captured while a frame streams in.
	localparam int POS_SRC_MAC   = 6;
	localparam int POS_SRC_END   = 11;
	localparam int POS_ARP_HDR   = 12;
	localparam int POS_ARP_END   = 19;
	localparam int POS_TARGET_IP = 38;
	localparam int POS_TARGET_END = 41;

	// Ethertype, htype, ptype, hlen and plen of an Ethernet/IPv4 ARP frame.
	localparam logic [63:0] ARP_SIGNATURE = 64'h0806_0001_0800_0604;

	// Outer header constants.
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL    = 8'h45;
	localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
	localparam logic [7:0]  IP_TTL        = 8'd64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOOK_RD,
		ST_LOOK_CMP,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  slot;
		logic [31:0] address;
		logic        enable;
	} tbl_wr_t;

endpackage

`default_nettype wire

### hw/rtl/arpenc_if.sv
// Stream interfaces for the input beats and the output words.
`default_nettype none

interface arpenc_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  data_byte;
	logic        frame_end;
	logic [3:0]  table_slot;
	logic [31:0] table_address;
	logic        table_enable;

	modport source (output valid, func, data_byte, frame_end, table_slot, table_address,
		table_enable, input ready);
	modport sink (input valid, func, data_byte, frame_end, table_slot, table_address,
		table_enable, output ready);
endinterface

interface arpenc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word;
	logic [3:0]  out_count;
	logic        out_last;

	modport source (output valid, out_word, out_count, out_last, input ready);
	modport sink (input valid, out_word, out_count, out_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/arpenc_frame_mem.sv
// Frame store: 64-bit words with byte-lane writes and a registered read.
`default_nettype none

module arpenc_frame_mem #(
	parameter int WORDS = 59
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(WORDS)-1:0] wr_addr,
	input  wire logic [2:0]               wr_lane,
	input  wire logic [7:0]               wr_byte,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(WORDS)-1:0] rd_addr,
	output logic      [63:0]              rd_data
);

	logic [63:0] mem [WORDS];

	// Lane 0 holds the earliest byte in the top bits.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int l = 0; l < 8; l++) begin
				if (wr_lane == 3'(l)) begin
					mem[wr_addr][8*(7-l) +: 8] <= wr_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/arpenc_addr_table.sv
// Address table: IPv4 addresses in a memory, valid bits in flip-flops.
`default_nettype none

module arpenc_addr_table #(
	parameter int ENTRIES = 16,
	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire arpenc_pkg::tbl_wr_t  wr,
	input  wire logic                 rd_en,
	input  wire logic [SLOT_W-1:0]    rd_slot,
	output logic      [31:0]          rd_address,
	output logic                      rd_valid
);

	logic [31:0]        mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic               wr_ok;
	logic [SLOT_W-1:0]  wr_idx;

	// Writes to slots past the table are dropped.
	assign wr_ok  = wr.en && (int'(wr.slot) < ENTRIES);
	assign wr_idx = SLOT_W'(wr.slot);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_idx] <= wr.address;
		end
		if (rd_en) begin
			rd_address <= mem[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_ok) begin
				valid_q[wr_idx] <= wr.enable;
			end
			if (rd_en) begin
				rd_valid <= valid_q[rd_slot];
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/arp_ipv4_encapsulator.sv
// Top level of the ARP-in-IPv4 encapsulator: control, header build and register port.
//
//   Channel | Dir | Handshake             | Beat carries
//   --------+-----+-----------------------+------------------------------------------
//   rx      | in  | valid/ready           | one frame byte, or one address table write
//   tx      | out | valid/ready           | one 8-byte word of an encapsulated frame
//   apb     | in  | psel/penable/pwrite   | outer destination MAC at 0x0, protocol at 0x8
//
// At the frame end the block checks the frame and scans the address table, reading and
// comparing each entry (the table memory has one read port with a registered output)
// until a hit or the last entry. On a hit it builds the ceil((len+20)/8) output words
// from the header and the frame store into the output register, waiting while tx holds
// ready low. Reset clears the control state and the table valid bits at once; the
// memories need no clearing pass. rx is ready only in the idle state; a finished last
// word may still wait in the output register while the next frame streams in.
`default_nettype none

module arp_ipv4_encapsulator #(
	parameter int MAX_FRAME     = 448,
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	arpenc_in_if.sink       rx,
	arpenc_out_if.source    tx,
	input  wire logic       psel,
	input  wire logic       penable,
	input  wire logic       pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic            pready
);

	// Frame bytes are stored HDR_GROWTH bytes further on, so that from word 4 on the
	// output words line up with the frame store words.
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int POS_W     = $clog2(MAX_FRAME + arpenc_pkg::HDR_GROWTH);
	localparam int TOT_W     = $clog2(MAX_FRAME + arpenc_pkg::HDR_GROWTH + 1);
	localparam int MEM_WORDS = (MAX_FRAME + arpenc_pkg::HDR_GROWTH + 7) / 8;
	localparam int AW        = $clog2(MEM_WORDS);
	localparam int SLOT_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	arpenc_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [47:0] dst_mac_q;
	logic [7:0]  proto_q;

	// Receive side.
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [CNT_W-1:0] len_q;
	logic             drop_ovf_q;
	logic [47:0]      src_mac_q;
	logic [63:0]      arp_hdr_q;
	logic [31:0]      tgt_q;

	// Lookup and emit.
	logic [SLOT_W-1:0] slot_q;
	logic [AW-1:0]     word_q;
	logic [AW-1:0]     last_word_q;
	logic [3:0]        last_cnt_q;
	logic [15:0]       ip_len_q;

	// Output register.
	logic        out_vld_q;
	logic [63:0] out_word_q;
	logic [3:0]  out_count_q;
	logic        out_last_q;

	// Control from the state machine.
	logic rx_rdy;
	logic tbl_rd;
	logic mem_rd;
	logic load_out;
	logic frame_bad;
	logic hit;
	logic last_slot;
	logic last_word;

	logic                rx_acc;
	logic                byte_acc;
	logic                store_byte;
	logic [POS_W-1:0]    wr_pos;
	logic [TOT_W-1:0]    tot_m1;
	logic [63:0]         mem_rd_data;
	logic [31:0]         tbl_address;
	logic                tbl_valid;
	arpenc_pkg::tbl_wr_t tbl_wr;

	logic [arpenc_pkg::HDR_BITS-1:0] hdr;
	logic [63:0]                     word_raw;
	logic [63:0]                     word_out;

	assign rx_acc     = rx.valid && rx_rdy;
	assign byte_acc   = rx_acc && (rx.func == arpenc_pkg::FUNC_FRAME);
	assign store_byte = cnt_q < CNT_W'(MAX_FRAME);
	assign wr_pos     = POS_W'(cnt_q) + POS_W'(arpenc_pkg::HDR_GROWTH);

	assign tbl_wr.en      = rx_acc && (rx.func == arpenc_pkg::FUNC_TABLE);
	assign tbl_wr.slot    = rx.table_slot;
	assign tbl_wr.address = rx.table_address;
	assign tbl_wr.enable  = rx.table_enable;

	arpenc_frame_mem #(
		.WORDS(MEM_WORDS)
	) u_frame_mem (
		.clk    (clk),
		.wr_en  (byte_acc && store_byte),
		.wr_addr(AW'(wr_pos[POS_W-1:3])),
		.wr_lane(wr_pos[2:0]),
		.wr_byte(rx.data_byte),
		.rd_en  (mem_rd),
		.rd_addr(word_q),
		.rd_data(mem_rd_data)
	);

	arpenc_addr_table #(
		.ENTRIES(TABLE_ENTRIES)
	) u_addr_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (tbl_wr),
		.rd_en     (tbl_rd),
		.rd_slot   (slot_q),
		.rd_address(tbl_address),
		.rd_valid  (tbl_valid)
	);

	// Frame checks on the captured header fields; the length can never exceed
	// MAX_FRAME because overflowing bytes are not counted.
	assign frame_bad = drop_ovf_q || (len_q < CNT_W'(arpenc_pkg::MIN_FRAME))
		|| (arp_hdr_q != arpenc_pkg::ARP_SIGNATURE);
	assign hit       = tbl_valid && (tbl_address == tgt_q);
	assign last_slot = slot_q == SLOT_W'(TABLE_ENTRIES - 1);
	assign last_word = word_q == last_word_q;
	assign tot_m1    = TOT_W'(len_q) + TOT_W'(arpenc_pkg::HDR_GROWTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arpenc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rx_rdy   = 1'b0;
		tbl_rd   = 1'b0;
		mem_rd   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			arpenc_pkg::ST_IDLE: begin
				rx_rdy = 1'b1;
				if (byte_acc && rx.frame_end) begin
					state_d = arpenc_pkg::ST_CHECK;
				end
			end
			arpenc_pkg::ST_CHECK: begin
				state_d = frame_bad ? arpenc_pkg::ST_IDLE : arpenc_pkg::ST_LOOK_RD;
			end
			arpenc_pkg::ST_LOOK_RD: begin
				tbl_rd  = 1'b1;
				state_d = arpenc_pkg::ST_LOOK_CMP;
			end
			arpenc_pkg::ST_LOOK_CMP: begin
				if (hit) begin
					state_d = arpenc_pkg::ST_EMIT_RD;
				end else if (last_slot) begin
					state_d = arpenc_pkg::ST_IDLE;
				end else begin
					state_d = arpenc_pkg::ST_LOOK_RD;
				end
			end
			arpenc_pkg::ST_EMIT_RD: begin
				mem_rd  = 1'b1;
				state_d = arpenc_pkg::ST_EMIT_WR;
			end
			arpenc_pkg::ST_EMIT_WR: begin
				// The read data stays in the memory output register until the
				// output register frees up.
				if (!out_vld_q || tx.ready) begin
					load_out = 1'b1;
					state_d  = last_word ? arpenc_pkg::ST_IDLE : arpenc_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = arpenc_pkg::ST_IDLE;
			end
		endcase
	end

	// Receive counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (byte_acc) begin
			if (rx.frame_end) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (store_byte) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Header fields are shifted in as their bytes pass by, in arrival order.
	always_ff @(posedge clk) begin
		if (byte_acc && store_byte) begin
			if (cnt_q >= CNT_W'(arpenc_pkg::POS_SRC_MAC)
				&& cnt_q <= CNT_W'(arpenc_pkg::POS_SRC_END)) begin
				src_mac_q <= {src_mac_q[39:0], rx.data_byte};
			end
			if (cnt_q >= CNT_W'(arpenc_pkg::POS_ARP_HDR)
				&& cnt_q <= CNT_W'(arpenc_pkg::POS_ARP_END)) begin
				arp_hdr_q <= {arp_hdr_q[55:0], rx.data_byte};
			end
			if (cnt_q >= CNT_W'(arpenc_pkg::POS_TARGET_IP)
				&& cnt_q <= CNT_W'(arpenc_pkg::POS_TARGET_END)) begin
				tgt_q <= {tgt_q[23:0], rx.data_byte};
			end
		end
		if (byte_acc && rx.frame_end) begin
			len_q      <= store_byte ? cnt_q + CNT_W'(1) : cnt_q;
			drop_ovf_q <= ovf_q || !store_byte;
		end
		if (state_q == arpenc_pkg::ST_CHECK) begin
			last_word_q <= AW'(tot_m1 >> 3);
			last_cnt_q  <= {1'b0, tot_m1[2:0]} + 4'd1;
			ip_len_q    <= 16'(len_q) + 16'(arpenc_pkg::IP_LEN_ADJ);
		end
	end

	// Scan and word counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			word_q <= '0;
		end else begin
			if (state_q == arpenc_pkg::ST_CHECK) begin
				slot_q <= '0;
				word_q <= '0;
			end else if (state_q == arpenc_pkg::ST_LOOK_CMP && !hit && !last_slot) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (load_out && !last_word) begin
				word_q <= word_q + AW'(1);
			end
		end
	end

	// Bytes 0 to 33 of the output: outer Ethernet header and IPv4 header.
	assign hdr = {dst_mac_q, src_mac_q, arpenc_pkg::ETH_TYPE_IPV4,
		arpenc_pkg::IP_VER_IHL, 8'h00, ip_len_q, 16'h0000, arpenc_pkg::IP_FLAGS_DF,
		arpenc_pkg::IP_TTL, proto_q, 16'h0000, tgt_q, tgt_q};

	always_comb begin
		if (word_q < AW'(arpenc_pkg::HDR_WORDS)) begin
			word_raw = hdr[(arpenc_pkg::HDR_BITS - 1) - 64 * int'(word_q[1:0]) -: 64];
		end else if (word_q == AW'(arpenc_pkg::HDR_WORDS)) begin
			// The last two header bytes share a word with the start of the ARP body.
			word_raw = {hdr[15:0], mem_rd_data[47:0]};
		end else begin
			word_raw = mem_rd_data;
		end
		// Bytes past the end of the frame read as zero.
		for (int l = 0; l < arpenc_pkg::WORD_BYTES; l++) begin
			if (last_word && (4'(l) >= last_cnt_q)) begin
				word_out[8*(7-l) +: 8] = 8'h00;
			end else begin
				word_out[8*(7-l) +: 8] = word_raw[8*(7-l) +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (tx.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q  <= word_out;
			out_count_q <= last_word ? last_cnt_q : 4'(arpenc_pkg::WORD_BYTES);
			out_last_q  <= last_word;
		end
	end

	assign rx.ready     = rx_rdy;
	assign tx.valid     = out_vld_q;
	assign tx.out_word  = out_word_q;
	assign tx.out_count = out_count_q;
	assign tx.out_last  = out_last_q;

	// Register port. A write lands at once, so software must change the registers only
	// while no frame is in flight; the block itself does not enforce this.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_mac_q <= '0;
			proto_q   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3])
				arpenc_pkg::REG_DST_MAC:     dst_mac_q <= pwdata[47:0];
				arpenc_pkg::REG_ENCAP_PROTO: proto_q   <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			arpenc_pkg::REG_DST_MAC:     prdata = {16'h0000, dst_mac_q};
			arpenc_pkg::REG_ENCAP_PROTO: prdata = {56'h0, proto_q};
		endcase
	end

	// A short word is always the final word of a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && !tx.out_last) |-> (tx.out_count == 4'(arpenc_pkg::WORD_BYTES)))
		else $error("short output word not marked last");

	// The last byte of a frame always leads to the check cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && (rx.func == arpenc_pkg::FUNC_FRAME) && rx.frame_end)
		|=> (state_q == arpenc_pkg::ST_CHECK))
		else $error("frame end did not start the frame check");

	// The word counter never runs past the last word of the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == arpenc_pkg::ST_EMIT_RD) || (state_q == arpenc_pkg::ST_EMIT_WR))
		|-> (word_q <= last_word_q))
		else $error("word counter past the last word");

	// The byte counter stays within the frame store.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FRAME))
		else $error("byte counter beyond the frame store");

endmodule

`default_nettype wire

### tb/arpenc_checker.sv
// Scoreboard for the ARP-in-IPv4 encapsulator: predicts output words and compares them.
`timescale 1ns / 100ps

module arpenc_checker #(
	parameter int MAX_FRAME     = 448,
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	arpenc_in_if             rx,
	arpenc_out_if            tx,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               words_due
);

	localparam int          MIN_LEN  = 42;
	localparam logic [63:0] ARP_HDR  = 64'h0806_0001_0800_0604;
	localparam int          MAX_SHOWN = 50;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  count;
		logic        last;
	} out_beat_t;

	logic [47:0] mac_reg   = '0;
	logic [7:0]  proto_reg = '0;
	logic [7:0]  fbytes [MAX_FRAME];
	int          fill      = 0;
	bit          overrun   = 1'b0;
	logic [31:0] ip_tab [TABLE_ENTRIES];
	bit          ip_ok  [TABLE_ENTRIES];
	out_beat_t   words_q [$];
	int          err_count = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (err_count < MAX_SHOWN)
			$display("checker: %s at %0t: got %h, want %h", what, $realtime, got, want);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			report(what, got, want);
	endtask

	// Works out the words of an encapsulated frame once its last byte is in.
	task automatic close_frame();
		logic [7:0]   ob [$];
		logic [31:0]  tgt;
		logic [15:0]  ip_len;
		logic [159:0] iphdr;
		out_beat_t    w;
		int           i, k, nwords, total, base;
		bit           hit;
		if (overrun || fill < MIN_LEN)
			return;
		if ({fbytes[12], fbytes[13], fbytes[14], fbytes[15],
			fbytes[16], fbytes[17], fbytes[18], fbytes[19]} != ARP_HDR)
			return;
		tgt = {fbytes[38], fbytes[39], fbytes[40], fbytes[41]};
		hit = 1'b0;
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (ip_ok[i] && ip_tab[i] == tgt)
				hit = 1'b1;
		if (!hit)
			return;
		for (i = 0; i < 6; i++)
			ob.push_back(mac_reg[47 - 8 * i -: 8]);
		for (i = 6; i < 12; i++)
			ob.push_back(fbytes[i]);
		ob.push_back(8'h08);
		ob.push_back(8'h00);
		// Version/IHL, TOS, length, id, DF flag, TTL, protocol, checksum, source, destination.
		ip_len = 16'(fill + 6);
		iphdr = {8'h45, 8'h00, ip_len, 16'h0000, 16'h4000, 8'd64, proto_reg, 16'h0000, tgt, tgt};
		for (i = 0; i < 20; i++)
			ob.push_back(iphdr[159 - 8 * i -: 8]);
		for (i = 14; i < fill; i++)
			ob.push_back(fbytes[i]);
		total = ob.size();
		nwords = (total + 7) / 8;
		for (k = 0; k < nwords; k++) begin
			base = 8 * k;
			w.word = '0;
			for (i = 0; i < 8; i++)
				if (base + i < total)
					w.word[63 - 8 * i -: 8] = ob[base + i];
			w.count = (total - base > 8) ? 4'd8 : 4'(total - base);
			w.last = (k == nwords - 1);
			words_q.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			mac_reg   = '0;
			proto_reg = '0;
			fill      = 0;
			overrun   = 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				ip_ok[i] = 1'b0;
			words_q.delete();
			words_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == arpenc_pkg::REG_DST_MAC)
					mac_reg = pwdata[47:0];
				else
					proto_reg = pwdata[7:0];
			end
			// Outgoing words are compared before this edge's input beat adds new ones.
			if (tx.valid && tx.ready) begin
				if (words_q.size() == 0) begin
					report("word with no frame pending", tx.out_word, '0);
				end else begin
					want = words_q.pop_front();
					check_field("out_word", tx.out_word, want.word);
					check_field("out_count", 64'(tx.out_count), 64'(want.count));
					check_field("out_last", 64'(tx.out_last), 64'(want.last));
				end
			end
			if (rx.valid && rx.ready) begin
				if (rx.func == arpenc_pkg::FUNC_TABLE) begin
					if (int'(rx.table_slot) < TABLE_ENTRIES) begin
						ip_tab[rx.table_slot] = rx.table_address;
						ip_ok[rx.table_slot]  = rx.table_enable;
					end
				end else begin
					if (fill < MAX_FRAME) begin
						fbytes[fill] = rx.data_byte;
						fill++;
					end else begin
						overrun = 1'b1;
					end
					if (rx.frame_end) begin
						close_frame();
						fill    = 0;
						overrun = 1'b0;
					end
				end
			end
			words_due <= words_q.size();
			errors    <= err_count;
		end
	end

endmodule

### tb/tb.sv
// Top of the encapsulator testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb;

	localparam int MAX_FRAME     = 448;
	localparam int TABLE_ENTRIES = 16;
	// Input beats to send over the whole run, frame bytes and table writes together.
	localparam int ITEMS         = 460;
	localparam int PHASES        = 4;
	// Cycles to let a dropped frame finish its check and table scan before a register write.
	localparam int SETTLE        = 2 * TABLE_ENTRIES + 16;
	// Cycles without any accepted beat after which the run is declared hung.
	localparam int QUIET_LIMIT   = 4000;
	localparam logic [63:0] ARP_HDR = 64'h0806_0001_0800_0604;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	wire  [63:0] prdata;
	wire         pready;
	int          fail_count;
	int          words_due;

	arpenc_in_if  rx_if ();
	arpenc_out_if tx_if ();

	arp_ipv4_encapsulator #(
		.MAX_FRAME     (MAX_FRAME),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.tx      (tx_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	arpenc_checker #(
		.MAX_FRAME     (MAX_FRAME),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.tx        (tx_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.errors    (fail_count),
		.words_due (words_due)
	);

	always #2 clk = ~clk;

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int gap_pct   = 0;
	int stall_pct = 0;
	// Input beats accepted so far.
	int beats_sent = 0;

	// The stimulus keeps its own view of the address table so that most frames can
	// name a target that the block knows, which is the only way to reach the encapsulation.
	logic [31:0] ip_mirror [TABLE_ENTRIES];
	bit          on_mirror [TABLE_ENTRIES];
	logic [7:0]  frame_q [$];

	// The receiver decides afresh every cycle whether it takes the next word.
	always @(posedge clk)
		tx_if.ready <= ($urandom_range(99) >= stall_pct);

	// Watchdog: any accepted beat on either channel restarts the count.
	int quiet = 0;
	always @(posedge clk) begin
		if (!arst_n || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Offers one beat, with a random hold-off first, and returns at the edge that takes it.
	// The valid line is left high so that the next beat can follow without a bubble.
	task automatic put_beat(input logic f, input logic [7:0] b, input logic fe,
		input logic [3:0] s, input logic [31:0] a, input logic en);
		while ($urandom_range(99) < gap_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid         <= 1'b1;
		rx_if.func          <= f;
		rx_if.data_byte     <= b;
		rx_if.frame_end     <= fe;
		rx_if.table_slot    <= s;
		rx_if.table_address <= a;
		rx_if.table_enable  <= en;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// A table write carries random junk in the frame fields, frame_end included,
	// since the block must ignore them on this kind of beat.
	task automatic table_write(input logic [3:0] s, input logic [31:0] a, input logic en);
		put_beat(arpenc_pkg::FUNC_TABLE, 8'($urandom_range(255)), 1'($urandom_range(1)),
			s, a, en);
		ip_mirror[s] = a;
		on_mirror[s] = en;
	endtask

	// Streams frame_q. A table write can be slipped in before byte mid_at; the block must
	// keep the partial frame and use the updated table for the lookup at the end.
	task automatic send_frame(input int mid_at, input logic [3:0] mslot,
		input logic [31:0] maddr, input logic men);
		int i;
		for (i = 0; i < frame_q.size(); i++) begin
			if (i == mid_at)
				table_write(mslot, maddr, men);
			put_beat(arpenc_pkg::FUNC_FRAME, frame_q[i], i == frame_q.size() - 1,
				4'($urandom_range(15)), $urandom, 1'($urandom_range(1)));
		end
	endtask

	// Builds a well-formed Ethernet/IPv4 ARP frame of the given length with random MACs,
	// random ARP fields and padding, and the given target IP. Short frames are simply cut.
	function automatic void make_arp(input int len, input logic [31:0] tgt);
		int i;
		frame_q.delete();
		for (i = 0; i < len; i++) begin
			if (i >= 12 && i < 20)
				frame_q.push_back(ARP_HDR[8 * (19 - i) +: 8]);
			else if (i >= 38 && i < 42)
				frame_q.push_back(tgt[8 * (41 - i) +: 8]);
			else
				frame_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	// Returns the address of some enabled table entry, enabling one first if none is.
	task automatic pick_known(output logic [31:0] ip);
		int live [$];
		int s;
		for (s = 0; s < TABLE_ENTRIES; s++)
			if (on_mirror[s])
				live.push_back(s);
		if (live.size() == 0) begin
			s = $urandom_range(TABLE_ENTRIES - 1);
			table_write(4'(s), $urandom, 1'b1);
			live.push_back(s);
		end
		ip = ip_mirror[live[$urandom_range(live.size() - 1)]];
	endtask

	// Stops the sender, waits for every predicted word to come out, then lets a frame
	// that is being dropped finish its table scan. Register writes happen only after this.
	task automatic quiesce();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: a setup phase, then an access phase that completes while pready is high.
	task automatic reg_write(input logic idx, input logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// One random transaction. Most are valid ARP frames aimed at a known target, so that
	// the encapsulation path is exercised with random content; the rest are table updates,
	// broken headers, unknown targets, short frames, and table writes that land in the
	// middle of a frame.
	task automatic random_txn();
		int          r, len, mid;
		logic [31:0] tgt;
		r = $urandom_range(99);
		if (r < 12) begin
			table_write(4'($urandom_range(15)), $urandom, $urandom_range(99) < 70);
			return;
		end
		// Now and then the sender waits for the output to drain completely.
		if (r < 15)
			quiesce();
		r = $urandom_range(99);
		if (r < 85)
			len = $urandom_range(64, 42);
		else if (r < 95)
			len = $urandom_range(120, 65);
		else
			len = $urandom_range(41, 1);
		r = $urandom_range(99);
		if (r < 85)
			pick_known(tgt);
		else if (r < 93)
			tgt = $urandom;
		else
			tgt = ip_mirror[$urandom_range(TABLE_ENTRIES - 1)];
		make_arp(len, tgt);
		if (len > 19 && $urandom_range(99) < 8)
			frame_q[$urandom_range(19, 12)] ^= 8'($urandom_range(255, 1));
		mid = ($urandom_range(99) < 6) ? $urandom_range(len - 1) : -1;
		send_frame(mid, 4'($urandom_range(15)), $urandom, 1'($urandom_range(1)));
	endtask

	initial begin : stimulus
		int i, ph, phase_end;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			ip_mirror[i] = '0;
			on_mirror[i] = 1'b0;
		end
		rx_if.valid         <= 1'b0;
		rx_if.func          <= arpenc_pkg::FUNC_FRAME;
		rx_if.data_byte     <= '0;
		rx_if.frame_end     <= 1'b0;
		rx_if.table_slot    <= '0;
		rx_if.table_address <= '0;
		rx_if.table_enable  <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the registers still at their reset values. The table gets
		// the all-zero and all-ones addresses plus one entry that is written but disabled.
		table_write(4'd0, 32'h0000_0000, 1'b1);
		table_write(4'd15, 32'hFFFF_FFFF, 1'b1);
		table_write(4'd7, 32'hC0A8_0107, 1'b0);
		// Shortest accepted frame.
		make_arp(42, 32'h0000_0000);
		send_frame(-1, '0, '0, 1'b0);
		// One byte too short.
		make_arp(41, 32'hFFFF_FFFF);
		send_frame(-1, '0, '0, 1'b0);
		// Wrong ethertype.
		make_arp(42, 32'hFFFF_FFFF);
		frame_q[13] ^= 8'h01;
		send_frame(-1, '0, '0, 1'b0);
		// Target held by a disabled entry.
		make_arp(42, 32'hC0A8_0107);
		send_frame(-1, '0, '0, 1'b0);
		// A table write in mid-frame adds the target; the output ends on a full word.
		make_arp(44, 32'h0A00_0002);
		send_frame(20, 4'd3, 32'h0A00_0002, 1'b1);
		// Output that ends with a single byte in its last word.
		make_arp(45, 32'h0A00_0002);
		send_frame(-1, '0, '0, 1'b0);

		// Random part, in phases with different idling, each behind a register change.
		// The remaining beat budget is split evenly over the phases.
		for (ph = 0; ph < PHASES; ph++) begin
			quiesce();
			case (ph)
				0: begin
					reg_write(arpenc_pkg::REG_DST_MAC, '1);
					reg_write(arpenc_pkg::REG_ENCAP_PROTO, '1);
					gap_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					reg_write(arpenc_pkg::REG_DST_MAC, {$urandom, $urandom});
					reg_write(arpenc_pkg::REG_ENCAP_PROTO, {$urandom, $urandom});
					gap_pct = 80;
					stall_pct <= 0;
				end
				2: begin
					reg_write(arpenc_pkg::REG_DST_MAC, '0);
					reg_write(arpenc_pkg::REG_ENCAP_PROTO, '0);
					gap_pct = 0;
					stall_pct <= 80;
				end
				default: begin
					reg_write(arpenc_pkg::REG_DST_MAC, {$urandom, $urandom});
					reg_write(arpenc_pkg::REG_ENCAP_PROTO, 64'($urandom_range(254, 1)));
					gap_pct = 27;
					stall_pct <= 27;
				end
			endcase
			phase_end = beats_sent + (ITEMS - beats_sent) / (PHASES - ph);
			do
				random_txn();
			while (beats_sent < phase_end);
		end

		// Drain everything, give the block time to show any stray word, then judge.
		quiesce();
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

### files.f
hw/rtl/arpenc_pkg.sv
hw/rtl/arpenc_if.sv
hw/rtl/arpenc_frame_mem.sv
hw/rtl/arpenc_addr_table.sv
hw/rtl/arp_ipv4_encapsulator.sv
tb/arpenc_checker.sv
tb/tb.sv
